/* rtl/vpo_pkg.sv */
// vpo_pkg: shared widths, register indexes and sequencer states for the vosim pulse oscillator
// used by every module under rtl; depends on nothing else
package vpo_pkg;

  localparam int PHASE_W   = 33;  // phase, one integer bit above q0.32
  localparam int INC_W     = 32;  // phase increment, q0.32
  localparam int HZ_W      = 23;  // magnitude of a non-negative q16.8 frequency
  localparam int AMP_W     = 18;  // pulse amplitude, signed q2.16
  localparam int TAB_W     = 17;  // sin-squared entry, q0.16 up to one
  localparam int SMP_W     = 16;  // output sample
  localparam int FADE_W    = 17;  // fade factor, q0.16 up to one
  localparam int ROUT_W    = 35;  // signed room left in the period
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 24;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DIV_W     = 33;
  localparam int DIV_STEPS = 33;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [AMP_W-1:0]  AMP_ONE   = 18'h1_0000;
  localparam logic [FADE_W-1:0] FADE_ONE  = 17'h1_0000;
  localparam logic [DIV_W-1:0]  RATIO_ONE = 33'h1_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_RATE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INC_F,
    S_INC_C,
    S_RATIO,
    S_LIM,
    S_ROUT,
    S_DECAY,
    S_FADE_DIV,
    S_FADE_MUL,
    S_POS,
    S_ROM_A,
    S_ROM_B,
    S_ROM_C,
    S_INTERP,
    S_SCALE,
    S_DONE
  } state_t;

endpackage

/* rtl/vpo_mul.sv */
// vpo_mul: bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
// one multiplier bit per cycle, stops early once the remaining bits are zero; uses vpo_pkg
module vpo_mul import vpo_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] mcand_in,
  input  logic [MUL_B_W-1:0] mplier_in,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  logic [MUL_P_W-1:0] acc;
  logic [MUL_P_W-1:0] mcand;
  logic [MUL_B_W-1:0] mplier;
  logic               busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        acc    <= '0;
        mcand  <= {{MUL_B_W{mcand_in[MUL_A_W-1]}}, mcand_in};
        mplier <= mplier_in;
        busy   <= 1'b1;
        done   <= 1'b0;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= {mcand[MUL_P_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[MUL_B_W-1:1]};
        done   <= (mplier[MUL_B_W-1:1] == '0);
        if (mplier[MUL_B_W-1:1] == '0) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign product = acc;

endmodule

/* rtl/vpo_div.sv */
// vpo_div: restoring divider, one quotient bit per cycle over a fixed number of steps
// the caller supplies a partial remainder below the divisor; uses vpo_pkg
module vpo_div import vpo_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] rem_init,
  input  logic [DIV_W-1:0] low_init,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] low;
  logic [DIV_W-1:0] dvsr;
  logic [CNT_W-1:0] count;
  logic             busy;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   trial_sub;
  logic             fits;

  assign trial     = {rem, low[DIV_W-1]};
  assign trial_sub = trial - {1'b0, dvsr};
  assign fits      = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      if (start) begin
        rem   <= rem_init;
        low   <= low_init;
        dvsr  <= divisor;
        count <= CNT_W'(DIV_STEPS);
        busy  <= 1'b1;
        done  <= 1'b0;
      end else if (busy) begin
        rem      <= fits ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
        low      <= {low[DIV_W-2:0], 1'b0};
        quotient <= {quotient[DIV_W-2:0], fits};
        count    <= count - 1'b1;
        done     <= (count == CNT_W'(1));
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

endmodule

/* rtl/vpo_rom.sv */
// vpo_rom: sin-squared lookup table built at elaboration, one registered read port
// uses vpo_pkg for the entry width
module vpo_rom import vpo_pkg::*; #(
  parameter int TABLE_SIZE = 512
) (
  input  logic                          clk,
  input  logic [$clog2(TABLE_SIZE)-1:0] addr,
  output logic [TAB_W-1:0]              data
);

  localparam logic [63:0] TABLE_LAST = 64'(TABLE_SIZE - 1);
  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [63:0] ONE_Q30    = 64'd1 << 30;

  typedef logic [TAB_W-1:0] rom_t [TABLE_SIZE];

  // taylor sine in q30 over the first half, mirrored, then squared
  function automatic logic [TAB_W-1:0] sq_entry(input logic [63:0] i);
    logic [63:0] k;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    logic [63:0] q;
    k  = (i <= TABLE_LAST - i) ? i : TABLE_LAST - i;
    x  = (PI_Q30 * k) / TABLE_LAST;
    x2 = (x * x) >> 30;
    p  = ONE_Q30;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd156;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd110;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd72;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd42;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd20;
    p  = ONE_Q30 - ((x2 * p) >> 30) / 64'd6;
    s  = (x * p) >> 30;
    q  = (s * s) >> 30;
    q  = (q + 64'd8192) >> 14;
    if (q > 64'd65536) begin
      q = 64'd65536;
    end
    return q[TAB_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      r[i] = sq_entry(64'(i));
    end
    return r;
  endfunction

  localparam rom_t SQ_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= SQ_ROM[addr];
  end

endmodule

/* rtl/vosim_pulse_oscillator.sv */
// vosim_pulse_oscillator: top level, sequencer, phase and amplitude state, output register
// instantiates vpo_mul, vpo_div and vpo_rom; uses vpo_pkg
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    fundamental_hz, center_hz
//   out      source     out_valid / out_stall  sample_out
//   cfg      sink       cfg_write              cfg_index, cfg_data
//
// one item at a time; each item runs through the shared bit-serial multiplier
// (one multiplier bit per cycle, up to 24) used up to seven times and the restoring
// divider (33 steps) used up to twice on an inner wrap
// in_stall is high from acceptance until the result is in the output register; a
// finished sample can wait there while the next item is taken
// synchronous reset loads register defaults, clears phases and increments, amplitude one
// a stalled output only holds the sequencer in its last state
module vosim_pulse_oscillator import vpo_pkg::*; #(
  parameter int TABLE_SIZE = 512
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [23:0]          fundamental_hz,
  input  logic [23:0]          center_hz,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SMP_W-1:0]     sample_out,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_SIZE);

  // configuration
  logic [31:0] rate_reciprocal;
  logic [15:0] decay_factor;
  logic [15:0] duty_limit;

  // oscillator state
  logic [PHASE_W-1:0] outer_phase;
  logic [PHASE_W-1:0] inner_phase;
  logic [INC_W-1:0]   outer_increment;
  logic [INC_W-1:0]   inner_increment;
  logic [INC_W-1:0]   wrap_residue;
  logic [AMP_W-1:0]   pulse_amplitude;

  // sequencer
  state_t state;
  state_t state_next;
  logic   issued;
  logic   issued_next;

  // per-item working registers
  logic [HZ_W-1:0]   fund_r;
  logic [HZ_W-1:0]   cent_r;
  logic              inner_wrap;
  logic [DIV_W-1:0]  ratio;
  logic [ROUT_W-1:0] rout;
  logic [FADE_W-1:0] fade;
  logic [ADDR_W-1:0] idx;
  logic [15:0]       frac;
  logic [TAB_W-1:0]  tab_a;
  logic [TAB_W:0]    tab_diff;
  logic [TAB_W-1:0]  interp;
  logic [SMP_W-1:0]  result;

  // serial units
  logic               mul_start;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic               mul_done;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start;
  logic [DIV_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_low;
  logic [DIV_W-1:0]   div_dvsr;
  logic               div_done;
  logic [DIV_W-1:0]   div_q;
  logic [ADDR_W-1:0]  rom_addr;
  logic [TAB_W-1:0]   rom_data;

  // input conditioning: negative fundamental is zero, centre floors at fundamental
  logic [HZ_W-1:0] fund_in;
  logic [HZ_W-1:0] cent_in;
  logic            in_accept;
  logic            need_load;

  assign fund_in   = fundamental_hz[23] ? '0 : fundamental_hz[HZ_W-1:0];
  assign cent_in   = ($signed(center_hz) < $signed({1'b0, fund_in})) ? fund_in
                                                                     : center_hz[HZ_W-1:0];
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  // reload when a phase wraps, or while the voice is silent, unset or unformed
  assign need_load = outer_phase[PHASE_W-1] || inner_phase[PHASE_W-1] ||
                     (outer_increment == '0) || (pulse_amplitude == '0) ||
                     (outer_increment == inner_increment);

  // increment from product: drop eight fraction bits, saturate below one cycle
  logic [INC_W-1:0] inc_sat;
  assign inc_sat = (mul_p[MUL_P_W-1:40] != '0) ? '1 : mul_p[39:8];

  // decay clamped to plus or minus one, kept as sign and magnitude
  logic        decay_neg;
  logic [15:0] decay_abs;
  logic [12:0] decay_mag;
  assign decay_neg = decay_factor[15];
  assign decay_abs = decay_neg ? 16'(-decay_factor) : decay_factor;
  assign decay_mag = (decay_abs > 16'd4096) ? 13'd4096 : decay_abs[12:0];

  logic [MUL_P_W-1:0] decay_prod;
  assign decay_prod = decay_neg ? MUL_P_W'(-mul_p) : mul_p;

  // room left in the period for another pulse
  logic [DIV_W-1:0]  one_minus_ratio;
  logic [DIV_W-1:0]  duty_q32;
  logic [DIV_W-1:0]  lim;
  logic [ROUT_W-1:0] rout_sub;
  logic              fade_needed;
  assign one_minus_ratio = RATIO_ONE - ratio;
  assign duty_q32        = {duty_limit, 17'd0};
  assign lim             = (duty_q32 < one_minus_ratio) ? duty_q32 : one_minus_ratio;
  assign rout_sub        = rout - {3'd0, wrap_residue};
  assign fade_needed     = (ratio != '0) && (rout[DIV_W-1:0] < ratio);

  logic [AMP_W-1:0] amp_ext_hi;
  logic [MUL_A_W-1:0] amp_ext;
  assign amp_ext_hi = pulse_amplitude;
  assign amp_ext    = {{(MUL_A_W-AMP_W){amp_ext_hi[AMP_W-1]}}, amp_ext_hi};

  // output scaling and saturation
  logic [16:0] scaled;
  logic [SMP_W-1:0] scaled_sat;
  assign scaled = mul_p[33:17];
  always_comb begin
    if (!scaled[16] && scaled[15]) begin
      scaled_sat = 16'h7FFF;
    end else if (scaled[16] && !scaled[15]) begin
      scaled_sat = 16'h8000;
    end else begin
      scaled_sat = scaled[15:0];
    end
  end

  logic [TAB_W:0] interp_sum;
  assign interp_sum = {1'b0, tab_a} + mul_p[33:16];

  assign rom_addr = (state == S_ROM_A) ? idx : ADDR_W'(idx + 1'b1);

  // sequencer: next state, unit starts and operand selection
  always_comb begin
    state_next = state;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_rem    = '0;
    div_low    = '0;
    div_dvsr   = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = need_load ? S_INC_F : S_POS;
        end
      end
      S_INC_F: begin
        mul_start = !issued;
        mul_a     = {1'b0, rate_reciprocal};
        mul_b     = {1'b0, fund_r};
        if (mul_done) begin
          state_next = S_INC_C;
        end
      end
      S_INC_C: begin
        mul_start = !issued;
        mul_a     = {1'b0, rate_reciprocal};
        mul_b     = {1'b0, cent_r};
        if (mul_done) begin
          if (!inner_wrap) begin
            state_next = S_POS;
          end else if (inc_sat == '0) begin
            state_next = S_LIM;
          end else begin
            state_next = S_RATIO;
          end
        end
      end
      S_RATIO: begin
        div_start = !issued;
        div_rem   = {2'd0, outer_increment[INC_W-1:1]};
        div_low   = {outer_increment[0], 32'd0};
        div_dvsr  = {1'b0, inner_increment};
        if (div_done) begin
          state_next = S_LIM;
        end
      end
      S_LIM: begin
        state_next = S_ROUT;
      end
      S_ROUT: begin
        state_next = rout_sub[ROUT_W-1] ? S_POS : S_DECAY;
      end
      S_DECAY: begin
        mul_start = !issued;
        mul_a     = amp_ext;
        mul_b     = {11'd0, decay_mag};
        if (mul_done) begin
          state_next = fade_needed ? S_FADE_DIV : S_FADE_MUL;
        end
      end
      S_FADE_DIV: begin
        div_start = !issued;
        div_rem   = {17'd0, rout[32:17]};
        div_low   = {rout[16:0], 16'd0};
        div_dvsr  = ratio;
        if (div_done) begin
          state_next = S_FADE_MUL;
        end
      end
      S_FADE_MUL: begin
        mul_start = !issued;
        mul_a     = amp_ext;
        mul_b     = {7'd0, fade};
        if (mul_done) begin
          state_next = S_POS;
        end
      end
      S_POS: begin
        mul_start = !issued;
        mul_a     = {1'b0, inner_phase[31:0]};
        mul_b     = MUL_B_W'(TABLE_SIZE - 1);
        if (mul_done) begin
          state_next = S_ROM_A;
        end
      end
      S_ROM_A: begin
        state_next = S_ROM_B;
      end
      S_ROM_B: begin
        state_next = S_ROM_C;
      end
      S_ROM_C: begin
        state_next = S_INTERP;
      end
      S_INTERP: begin
        mul_start = !issued;
        mul_a     = {{(MUL_A_W-TAB_W-1){tab_diff[TAB_W]}}, tab_diff};
        mul_b     = {8'd0, frac};
        if (mul_done) begin
          state_next = S_SCALE;
        end
      end
      S_SCALE: begin
        mul_start = !issued;
        mul_a     = amp_ext;
        mul_b     = {7'd0, interp};
        if (mul_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (mul_start || div_start) begin
      issued_next = 1'b1;
    end else if (mul_done || div_done) begin
      issued_next = 1'b0;
    end else begin
      issued_next = issued;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      issued          <= 1'b0;
      out_valid       <= 1'b0;
      rate_reciprocal <= 32'd89478;
      decay_factor    <= 16'd0;
      duty_limit      <= 16'h8000;
      outer_phase     <= '0;
      inner_phase     <= '0;
      outer_increment <= '0;
      inner_increment <= '0;
      wrap_residue    <= '0;
      pulse_amplitude <= AMP_ONE;
    end else begin
      state  <= state_next;
      issued <= issued_next;

      if (cfg_write) begin
        case (cfg_index)
          REG_RATE:  rate_reciprocal <= cfg_data;
          REG_DECAY: decay_factor    <= cfg_data[15:0];
          REG_DUTY:  duty_limit      <= cfg_data[15:0];
          default: ;
        endcase
      end

      // a sample leaving with no new one behind it
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            fund_r     <= fund_in;
            cent_r     <= cent_in;
            inner_wrap <= !outer_phase[PHASE_W-1] && inner_phase[PHASE_W-1];
            if (outer_phase[PHASE_W-1]) begin
              // outer wrap: new burst at full amplitude
              pulse_amplitude <= AMP_ONE;
              outer_phase     <= {1'b0, outer_phase[31:0]};
              wrap_residue    <= outer_phase[31:0];
              inner_phase     <= '0;
            end else if (inner_phase[PHASE_W-1]) begin
              inner_phase <= {1'b0, inner_phase[31:0]};
            end
          end
        end
        S_INC_F: begin
          if (mul_done) begin
            outer_increment <= inc_sat;
          end
        end
        S_INC_C: begin
          if (mul_done) begin
            inner_increment <= inc_sat;
            // no inner motion: ratio counts as one
            if (inc_sat == '0) begin
              ratio <= RATIO_ONE;
            end
          end
        end
        S_RATIO: begin
          if (div_done) begin
            ratio <= div_q;
          end
        end
        S_LIM: begin
          rout <= {2'd0, lim} - {2'd0, outer_phase};
        end
        S_ROUT: begin
          rout <= rout_sub;
          // pulse would spill past the limit: silence
          if (rout_sub[ROUT_W-1]) begin
            pulse_amplitude <= '0;
          end
        end
        S_DECAY: begin
          if (mul_done) begin
            pulse_amplitude <= decay_prod[29:12];
            fade            <= FADE_ONE;
          end
        end
        S_FADE_DIV: begin
          if (div_done) begin
            fade <= div_q[FADE_W-1:0];
          end
        end
        S_FADE_MUL: begin
          if (mul_done) begin
            pulse_amplitude <= mul_p[33:16];
          end
        end
        S_POS: begin
          if (mul_done) begin
            idx  <= mul_p[32 +: ADDR_W];
            frac <= mul_p[31:16];
          end
        end
        S_ROM_B: begin
          tab_a <= rom_data;
        end
        S_ROM_C: begin
          tab_diff <= {1'b0, rom_data} - {1'b0, tab_a};
        end
        S_INTERP: begin
          if (mul_done) begin
            interp <= interp_sum[TAB_W-1:0];
          end
        end
        S_SCALE: begin
          if (mul_done) begin
            result <= scaled_sat;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            sample_out  <= result;
            out_valid   <= 1'b1;
            outer_phase <= outer_phase + {1'b0, outer_increment};
            inner_phase <= inner_phase + {1'b0, inner_increment};
          end
        end
        default: ;
      endcase
    end
  end

  vpo_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (mul_a),
    .mplier_in (mul_b),
    .done      (mul_done),
    .product   (mul_p)
  );

  vpo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem),
    .low_init (div_low),
    .divisor  (div_dvsr),
    .done     (div_done),
    .quotient (div_q)
  );

  vpo_rom #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  // an outer wrap at acceptance restarts the burst
  a_burst_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && outer_phase[PHASE_W-1]) |=>
      (pulse_amplitude == AMP_ONE && inner_phase == '0))
    else $error("burst restart missed");

  // centre is floored at fundamental, so between items the increments stay ordered
  a_inc_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (outer_increment <= inner_increment))
    else $error("increments out of order");

  // a finished sample reaches the output register and frees the input side
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || !out_stall)) |=> (out_valid && !in_stall))
    else $error("result not delivered");

endmodule
